>>> rtl/core/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared constants, types and helper functions for the remote-control frame
// decoder with key and mouse-button edge counters.
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int FRAME_LENGTH   = 18;
    localparam int KEY_BITS       = 16;
    localparam int MODIFIER_MODES = 4;
    localparam int COUNT_WIDTH    = 16;

    localparam int CH_W       = 11;
    localparam int CH_LIMIT   = 660;
    localparam int SHIFT_BIT  = 4;
    localparam int CTRL_BIT   = 5;
    localparam int POS_W      = $clog2(FRAME_LENGTH + 1);
    localparam int MODE_W     = $clog2(MODIFIER_MODES);
    localparam int KEY_COL_W  = $clog2(KEY_BITS);
    localparam int IDX_W      = 7;
    localparam int KEY_COUNTERS = MODIFIER_MODES * KEY_BITS;

    localparam logic [IDX_W-1:0] MOUSE_LEFT_IDX  = IDX_W'(KEY_COUNTERS);
    localparam logic [IDX_W-1:0] MOUSE_RIGHT_IDX = IDX_W'(KEY_COUNTERS + 1);

    localparam logic [CH_W-1:0]     CENTER_RESET = CH_W'(1024);
    localparam logic [KEY_BITS-1:0] MODIFIER_MASK =
        KEY_BITS'((1 << SHIFT_BIT) | (1 << CTRL_BIT));

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 1;
    localparam int M_FIELDS_W = 5 * CH_W + 4 + 5 * 16;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        W_DECODE = 2'd0,
        W_READ   = 2'd1,
        W_CLEAR  = 2'd2,
        W_NOP    = 2'd3
    } t_work;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_READ  = 1'b1
    } t_kind;

    typedef logic [FRAME_LENGTH-1:0][7:0]          t_frame;
    typedef logic [KEY_BITS-1:0][COUNT_WIDTH-1:0]  t_row;

    typedef struct packed {
        t_work              work;
        t_frame             frame;
        logic [IDX_W-1:0]   idx;
    } t_item;

    typedef struct packed {
        logic               go;
        t_work              work;
        logic [KEY_BITS-1:0] keys;
        logic [7:0]         left;
        logic [7:0]         right;
        logic [IDX_W-1:0]   idx;
    } t_cnt_upd;

    function automatic logic [MODE_W-1:0] key_mode(input logic [KEY_BITS-1:0] keys);
        return {keys[CTRL_BIT], keys[SHIFT_BIT]};
    endfunction

    function automatic logic [CH_W-1:0] centre(input logic [CH_W-1:0] raw,
                                               input logic [CH_W-1:0] offset);
        logic signed [CH_W:0] v;
        v = $signed({1'b0, raw}) - $signed({1'b0, offset});
        if (v > (CH_W+1)'(CH_LIMIT) || v < -(CH_W+1)'(CH_LIMIT)) begin
            v = '0;
        end
        return v[CH_W-1:0];
    endfunction

endpackage

>>> rtl/core/remote_frame_decoder_with_key_edges.sv
// ----------------------------------------------------------------------------
// remote_frame_decoder_with_key_edges
// Collects 18-byte remote-control frames, decodes sticks, dial, switches, mouse
// and keys, and counts rising key and mouse-button edges for readback.
// ----------------------------------------------------------------------------
// Path: an accepted beat is registered in the decode stage; a result beat
// moves on into the output register when free; others leave it without waiting.
// Throughput: one input beat per cycle, set by the single decode stage and the
// key counter row memory (one read and one write port, with write bypass),
// as long as no result beat waits in the decode stage for the output register.
// Reset: synchronous, active low; center_offset returns to 1024, the frame
// position waits for a frame start, and all edge counters and history read 0.
// ----------------------------------------------------------------------------
module remote_frame_decoder_with_key_edges (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // data_byte[7:0], counter_index[14:8], zero pad[15].
    input  logic [rfd_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // op[1:0], frame_start[2].
    input  logic [rfd_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // right_horizontal[10:0], right_vertical[21:11], left_horizontal[32:22],
    // left_vertical[43:33], dial_value[54:44], switch_bits[58:55],
    // mouse_dx[74:59], mouse_dy[90:75], mouse_press[106:91],
    // key_word[122:107], count_value[138:123], zero pad[143:139].
    output logic [rfd_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // kind[0].
    output logic [rfd_pkg::M_TUSER_W-1:0]   o_m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import rfd_pkg::*;

    logic [CH_W-1:0]        r_center;
    logic                   r_s1_valid;
    t_item                  r_s1;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;
    t_kind                  r_out_kind;

    logic                   accept;
    logic                   has_result;
    logic                   out_free;
    logic                   s1_go;
    t_op                    in_op;
    logic [IDX_W-1:0]       in_idx;
    t_work                  c_work;
    t_frame                 c_frame;
    logic [MODE_W-1:0]      c_mode;
    logic [MODE_W-1:0]      rd_row;
    t_cnt_upd               upd;
    logic [COUNT_WIDTH-1:0] count;
    logic [M_FIELDS_W-1:0]  fields;
    t_frame                 b;

    assign pready = 1'b1;
    assign prdata = {{(32-CH_W){1'b0}}, r_center};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_center <= pwdata[CH_W-1:0];
        end
    end

    assign in_op  = t_op'(i_s_axis_tuser[1:0]);
    assign in_idx = i_s_axis_tdata[8 +: IDX_W];

    assign has_result = (r_s1.work == W_DECODE) || (r_s1.work == W_READ);
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign s1_go      = r_s1_valid && (!has_result || out_free);
    assign o_s_axis_tready = !r_s1_valid || s1_go;
    assign accept     = i_s_axis_tvalid && o_s_axis_tready;

    rfd_collect u_collect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (in_op),
        .i_byte   (i_s_axis_tdata[7:0]),
        .i_start  (i_s_axis_tuser[2]),
        .o_work   (c_work),
        .o_frame  (c_frame),
        .o_mode   (c_mode)
    );

    assign rd_row = (in_op == OP_READ) ? in_idx[KEY_COL_W +: MODE_W] : c_mode;

    assign b          = r_s1.frame;
    assign upd.go     = s1_go;
    assign upd.work   = r_s1.work;
    assign upd.keys   = {b[15], b[14]};
    assign upd.left   = b[12];
    assign upd.right  = b[13];
    assign upd.idx    = r_s1.idx;

    rfd_counters u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_row (rd_row),
        .i_upd    (upd),
        .o_count  (count)
    );

    always_comb begin
        if (r_s1.work == W_DECODE) begin
            fields = {16'd0,
                      b[15], b[14],
                      b[13], b[12],
                      b[9], b[8],
                      b[7], b[6],
                      b[5][7:4],
                      centre({b[17][2:0], b[16]}, r_center),
                      centre({b[5][3:0], b[4][7:1]}, r_center),
                      centre({b[4][0], b[3], b[2][7:6]}, r_center),
                      centre({b[2][5:0], b[1][7:3]}, r_center),
                      centre({b[1][2:0], b[0]}, r_center)};
        end else begin
            fields = {count, {(M_FIELDS_W-16){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.work  <= c_work;
            r_s1.frame <= c_frame;
            r_s1.idx   <= in_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && has_result) begin
            r_out_data <= {{(M_TDATA_W-M_FIELDS_W){1'b0}}, fields};
            r_out_kind <= (r_s1.work == W_READ) ? KIND_READ : KIND_FRAME;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;

endmodule

>>> rtl/core/rfd_collect.sv
// ----------------------------------------------------------------------------
// rfd_collect
// Tracks the byte position of the current frame and gathers frame bytes in a
// shift line; classifies each accepted beat for the decode stage.
// ----------------------------------------------------------------------------
module rfd_collect (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  rfd_pkg::t_op                i_op,
    input  logic [7:0]                  i_byte,
    input  logic                        i_start,
    output rfd_pkg::t_work              o_work,
    output rfd_pkg::t_frame             o_frame,
    output logic [rfd_pkg::MODE_W-1:0]  o_mode
);
    import rfd_pkg::*;

    logic [POS_W-1:0]              r_pos;
    logic [POS_W-1:0]              n_pos;
    logic [FRAME_LENGTH-2:0][7:0]  r_fb;
    logic [POS_W-1:0]              pos_eff;
    logic                          store;

    assign pos_eff = i_start ? '0 : r_pos;
    assign o_frame = {i_byte, r_fb};
    assign o_mode  = key_mode({r_fb[15], r_fb[14]});

    always_comb begin
        o_work = W_NOP;
        store  = 1'b0;
        n_pos  = r_pos;
        unique case (i_op)
            OP_PUSH: begin
                if (pos_eff == POS_W'(FRAME_LENGTH - 1)) begin
                    o_work = W_DECODE;
                    n_pos  = POS_W'(FRAME_LENGTH);
                end else if (pos_eff < POS_W'(FRAME_LENGTH - 1)) begin
                    store = 1'b1;
                    n_pos = pos_eff + POS_W'(1);
                end
            end
            OP_READ: begin
                o_work = W_READ;
            end
            OP_CLEAR: begin
                o_work = W_CLEAR;
                n_pos  = POS_W'(FRAME_LENGTH);
            end
            OP_NONE: begin
                o_work = W_NOP;
            end
            default: begin
                o_work = W_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_W'(FRAME_LENGTH);
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && store) begin
            r_fb <= {i_byte, r_fb[FRAME_LENGTH-2:1]};
        end
    end

endmodule

>>> rtl/core/rfd_counters.sv
// ----------------------------------------------------------------------------
// rfd_counters
// Key and mouse-button rising-edge counters. Key counters live in a row
// memory, one row per modifier mode, with row valid bits for clearing and a
// bypass for a read that meets a write of the same row.
// ----------------------------------------------------------------------------
module rfd_counters (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [rfd_pkg::MODE_W-1:0]      i_rd_row,
    input  rfd_pkg::t_cnt_upd               i_upd,
    output logic [rfd_pkg::COUNT_WIDTH-1:0] o_count
);
    import rfd_pkg::*;

    t_row                         r_mem [MODIFIER_MODES];
    t_row                         r_q;
    t_row                         r_wq;
    logic                         r_byp;
    logic                         r_qvalid;
    logic [MODIFIER_MODES-1:0]    r_row_valid;
    logic [KEY_BITS-1:0]          r_last [MODIFIER_MODES];
    logic [1:0][7:0]              r_last_mouse;
    logic [1:0][COUNT_WIDTH-1:0]  r_mouse_cnt;

    t_row                         cur_row;
    t_row                         new_row;
    logic [KEY_BITS-1:0]          rise;
    logic [MODE_W-1:0]            mode;
    logic                         wr_en;
    logic                         clr;
    logic [1:0]                   press_now;
    logic [1:0]                   mouse_rise;

    assign mode    = key_mode(i_upd.keys);
    assign wr_en   = i_upd.go && (i_upd.work == W_DECODE);
    assign clr     = i_upd.go && (i_upd.work == W_CLEAR);
    assign cur_row = !r_qvalid ? '0 : (r_byp ? r_wq : r_q);
    assign rise    = i_upd.keys & ~r_last[mode] & ~MODIFIER_MASK;

    assign press_now  = {i_upd.right != 8'd0, i_upd.left != 8'd0};
    assign mouse_rise = {press_now[1] && (r_last_mouse[1] == 8'd0),
                         press_now[0] && (r_last_mouse[0] == 8'd0)};

    always_comb begin
        for (int c = 0; c < KEY_BITS; c++) begin
            new_row[c] = cur_row[c] + COUNT_WIDTH'(rise[c]);
        end
    end

    always_comb begin
        if (i_upd.idx < IDX_W'(KEY_COUNTERS)) begin
            o_count = cur_row[i_upd.idx[KEY_COL_W-1:0]];
        end else if (i_upd.idx == MOUSE_LEFT_IDX) begin
            o_count = r_mouse_cnt[0];
        end else if (i_upd.idx == MOUSE_RIGHT_IDX) begin
            o_count = r_mouse_cnt[1];
        end else begin
            o_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[mode] <= new_row;
        end
        if (i_rd_en) begin
            r_q  <= r_mem[i_rd_row];
            r_wq <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp    <= 1'b0;
            r_qvalid <= 1'b0;
        end else if (i_rd_en) begin
            r_byp    <= wr_en && (mode == i_rd_row);
            r_qvalid <= !clr && ((wr_en && (mode == i_rd_row)) || r_row_valid[i_rd_row]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_row_valid  <= '0;
            r_last_mouse <= '0;
            r_mouse_cnt  <= '0;
            for (int m = 0; m < MODIFIER_MODES; m++) begin
                r_last[m] <= '0;
            end
        end else if (wr_en) begin
            r_row_valid[mode] <= 1'b1;
            r_last_mouse      <= {i_upd.right, i_upd.left};
            for (int k = 0; k < 2; k++) begin
                r_mouse_cnt[k] <= r_mouse_cnt[k] + COUNT_WIDTH'(mouse_rise[k]);
            end
            for (int m = 0; m < MODIFIER_MODES; m++) begin
                r_last[m] <= (MODE_W'(m) == mode) ? i_upd.keys : '0;
            end
        end
    end

endmodule

>>> dv/frame_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_decode_checker
// Watches the input, output and register channels of the remote-control frame
// decoder. It keeps its own copy of the frame buffer, key history and edge
// counters, predicts every reply beat from the accepted input beats, and
// compares each output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_decode_checker #(
    parameter logic [2:0] CENTER_ADDR = 3'd0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [rfd_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [rfd_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [rfd_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic [rfd_pkg::M_TUSER_W-1:0] i_m_tuser,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [2:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import rfd_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [10:0] right_h;
        logic [10:0] right_v;
        logic [10:0] left_h;
        logic [10:0] left_v;
        logic [10:0] dial;
        logic [3:0]  switches;
        logic [15:0] mouse_dx;
        logic [15:0] mouse_dy;
        logic [15:0] mouse_press;
        logic [15:0] key_word;
        logic [15:0] count_value;
    } reply_t;

    logic [CH_W-1:0]     center_offset;
    logic [7:0]          frame_buf [FRAME_LENGTH];
    int                  byte_pos;
    logic [KEY_BITS-1:0] prev_mode_keys [MODIFIER_MODES];
    logic [7:0]          prev_buttons [2];
    logic [15:0]         key_edges [KEY_COUNTERS];
    logic [15:0]         button_edges [2];
    reply_t              awaited_replies [$];
    int                  failures = 0;

    assign o_fail_count = failures;

    function automatic logic [CH_W-1:0] center_channel(input logic [CH_W-1:0] raw);
        int v;
        v = int'(raw) - int'(center_offset);
        if (v > CH_LIMIT || v < -CH_LIMIT) begin
            v = 0;
        end
        return v[CH_W-1:0];
    endfunction

    task automatic forget_link();
        byte_pos = FRAME_LENGTH;
        for (int k = 0; k < FRAME_LENGTH; k++) begin
            frame_buf[k] = '0;
        end
        for (int m = 0; m < MODIFIER_MODES; m++) begin
            prev_mode_keys[m] = '0;
        end
        for (int k = 0; k < KEY_COUNTERS; k++) begin
            key_edges[k] = '0;
        end
        for (int b = 0; b < 2; b++) begin
            prev_buttons[b] = '0;
            button_edges[b] = '0;
        end
    endtask

    task automatic decode_frame(output reply_t r);
        logic [15:0] keys;
        logic [1:0]  mode;
        logic [15:0] now_keys;
        logic [15:0] rising;
        keys = {frame_buf[15], frame_buf[14]};
        mode = {keys[CTRL_BIT], keys[SHIFT_BIT]};
        r = '0;
        r.kind        = KIND_FRAME;
        r.right_h     = center_channel(11'({frame_buf[1], frame_buf[0]}));
        r.right_v     = center_channel(11'({frame_buf[2], frame_buf[1]} >> 3));
        r.left_h      = center_channel(11'({frame_buf[4], frame_buf[3], frame_buf[2]} >> 6));
        r.left_v      = center_channel(11'({frame_buf[5], frame_buf[4]} >> 1));
        r.dial        = center_channel(11'({frame_buf[17], frame_buf[16]}));
        r.switches    = frame_buf[5][7:4];
        r.mouse_dx    = {frame_buf[7], frame_buf[6]};
        r.mouse_dy    = {frame_buf[9], frame_buf[8]};
        r.mouse_press = {frame_buf[13], frame_buf[12]};
        r.key_word    = keys;

        // Only the active modifier mode sees the keys; the others see a release.
        for (int m = 0; m < MODIFIER_MODES; m++) begin
            now_keys = (m == mode) ? keys : '0;
            rising   = now_keys & ~prev_mode_keys[m];
            for (int k = 0; k < KEY_BITS; k++) begin
                if (k != SHIFT_BIT && k != CTRL_BIT && rising[k]) begin
                    key_edges[m * KEY_BITS + k] += 16'd1;
                end
            end
            prev_mode_keys[m] = now_keys;
        end
        for (int b = 0; b < 2; b++) begin
            if (frame_buf[12 + b] != 8'd0 && prev_buttons[b] == 8'd0) begin
                button_edges[b] += 16'd1;
            end
            prev_buttons[b] = frame_buf[12 + b];
        end
    endtask

    task automatic advance_decoder(input logic [1:0] op_bits, input logic [7:0] data,
                                   input logic start, input logic [IDX_W-1:0] idx);
        t_op    op;
        reply_t r;
        op = t_op'(op_bits);
        case (op)
            OP_PUSH: begin
                if (start) begin
                    byte_pos = 0;
                end
                if (byte_pos < FRAME_LENGTH) begin
                    frame_buf[byte_pos] = data;
                    byte_pos++;
                    if (byte_pos == FRAME_LENGTH) begin
                        decode_frame(r);
                        awaited_replies.push_back(r);
                    end
                end
            end
            OP_READ: begin
                r = '0;
                r.kind = KIND_READ;
                if (idx < KEY_COUNTERS) begin
                    r.count_value = key_edges[idx];
                end else if (idx == MOUSE_LEFT_IDX) begin
                    r.count_value = button_edges[0];
                end else if (idx == MOUSE_RIGHT_IDX) begin
                    r.count_value = button_edges[1];
                end
                awaited_replies.push_back(r);
            end
            OP_CLEAR: begin
                forget_link();
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= 10) begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        reply_t want;
        reply_t got;
        if (!i_rst_n) begin
            center_offset = CENTER_RESET;
            forget_link();
            awaited_replies.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == CENTER_ADDR) begin
                center_offset = i_pwdata[CH_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_decoder(i_s_tuser[1:0], i_s_tdata[7:0], i_s_tuser[2],
                                i_s_tdata[14:8]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_replies.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: reply beat with nothing awaited, tdata %h", $time,
                                 i_m_tdata);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    got.kind        = i_m_tuser[0];
                    got.right_h     = i_m_tdata[10:0];
                    got.right_v     = i_m_tdata[21:11];
                    got.left_h      = i_m_tdata[32:22];
                    got.left_v      = i_m_tdata[43:33];
                    got.dial        = i_m_tdata[54:44];
                    got.switches    = i_m_tdata[58:55];
                    got.mouse_dx    = i_m_tdata[74:59];
                    got.mouse_dy    = i_m_tdata[90:75];
                    got.mouse_press = i_m_tdata[106:91];
                    got.key_word    = i_m_tdata[122:107];
                    got.count_value = i_m_tdata[138:123];
                    check_field("kind", 16'(want.kind), 16'(got.kind));
                    check_field("right_horizontal", 16'(want.right_h), 16'(got.right_h));
                    check_field("right_vertical", 16'(want.right_v), 16'(got.right_v));
                    check_field("left_horizontal", 16'(want.left_h), 16'(got.left_h));
                    check_field("left_vertical", 16'(want.left_v), 16'(got.left_v));
                    check_field("dial_value", 16'(want.dial), 16'(got.dial));
                    check_field("switch_bits", 16'(want.switches), 16'(got.switches));
                    check_field("mouse_dx", want.mouse_dx, got.mouse_dx);
                    check_field("mouse_dy", want.mouse_dy, got.mouse_dy);
                    check_field("mouse_press", want.mouse_press, got.mouse_press);
                    check_field("key_word", want.key_word, got.key_word);
                    check_field("count_value", want.count_value, got.count_value);
                end
            end
        end
        o_pending <= awaited_replies.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the remote-control frame decoder with a short directed sequence and
// then random phases of well-formed frames, truncated frames, counter reads,
// link-lost clears and noise, each phase under a new center offset. Both
// stream sides idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import rfd_pkg::*;

    localparam logic [2:0] CENTER_OFFSET_ADDR = 3'd0;
    localparam int         PHASE_BEATS        = 150;
    localparam int         PHASES             = 7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    int                   beats_sent = 0;
    logic [CH_W-1:0]      center_now = CENTER_RESET;
    logic [15:0]          held_keys = '0;
    bit                   sender_steady = 1'b0;
    bit                   sink_steady = 1'b0;

    remote_frame_decoder_with_key_edges dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    frame_decode_checker #(
        .CENTER_ADDR (CENTER_OFFSET_ADDR)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_beat(input t_op op, input logic [7:0] data, input logic start,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx, data};
        s_tuser  <= {start, op};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_center(input logic [CH_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CENTER_OFFSET_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        center_now = value;
    endtask

    function automatic logic [IDX_W-1:0] counter_pick();
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom_range(KEY_COUNTERS + 2, 127));
            1: return $urandom_range(0, 1) ? MOUSE_LEFT_IDX : MOUSE_RIGHT_IDX;
            default: return IDX_W'($urandom_range(0, KEY_COUNTERS - 1));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] raw_near_center();
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 2047);
            1: begin
                v = 660 + $urandom_range(0, 1);
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
                v = v + int'(center_now);
            end
            default: v = int'(center_now) + int'($urandom_range(0, 1400)) - 700;
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 2047) begin
            v = 2047;
        end
        return v[CH_W-1:0];
    endfunction

    task automatic send_frame(input bit broken, input bit with_reads);
        t_frame          f;
        logic [CH_W-1:0] ch [5];
        logic [15:0]     keys;
        int              stop;
        for (int c = 0; c < 5; c++) begin
            ch[c] = raw_near_center();
        end
        for (int k = 0; k < FRAME_LENGTH; k++) begin
            f[k] = 8'($urandom);
        end
        if ($urandom_range(0, 3) == 0) begin
            keys = held_keys;
        end else begin
            keys = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom & $urandom & $urandom);
            keys[SHIFT_BIT] = 1'($urandom_range(0, 1));
            keys[CTRL_BIT]  = 1'($urandom_range(0, 1));
        end
        held_keys = keys;
        f[0]       = ch[0][7:0];
        f[1]       = {ch[1][4:0], ch[0][10:8]};
        f[2]       = {ch[2][1:0], ch[1][10:5]};
        f[3]       = ch[2][9:2];
        f[4]       = {ch[3][6:0], ch[2][10]};
        f[5][3:0]  = ch[3][10:7];
        f[16]      = ch[4][7:0];
        f[17][2:0] = ch[4][10:8];
        f[14]      = keys[7:0];
        f[15]      = keys[15:8];
        for (int b = 0; b < 2; b++) begin
            f[12 + b] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
        end
        stop = broken ? $urandom_range(1, FRAME_LENGTH - 1) : FRAME_LENGTH;
        for (int k = 0; k < stop; k++) begin
            if (with_reads && $urandom_range(0, 5) == 0) begin
                send_beat(OP_READ, 8'($urandom), 1'($urandom), counter_pick());
            end
            send_beat(OP_PUSH, f[k], k == 0, IDX_W'($urandom));
        end
    endtask

    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = sink_steady ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin
        int draw;
        int goal;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(OP_NONE, 8'hA5, 1'b1, 7'h7F);
        send_beat(OP_PUSH, 8'h5A, 1'b0, 7'h00);
        send_beat(OP_READ, 8'h00, 1'b0, 7'h00);
        send_beat(OP_READ, 8'hFF, 1'b1, 7'h7F);
        send_beat(OP_PUSH, 8'h00, 1'b1, 7'h00);
        send_beat(OP_PUSH, 8'h00, 1'b0, 7'h00);
        for (int k = 0; k < FRAME_LENGTH; k++) begin
            send_beat(OP_PUSH, 8'hFF, k == 0, 7'h00);
        end
        send_beat(OP_READ, 8'h00, 1'b0, IDX_W'(3 * KEY_BITS));
        send_beat(OP_READ, 8'h00, 1'b0, MOUSE_LEFT_IDX);
        send_beat(OP_READ, 8'h00, 1'b0, MOUSE_RIGHT_IDX);
        send_beat(OP_CLEAR, 8'h00, 1'b0, 7'h00);
        send_beat(OP_READ, 8'h00, 1'b0, IDX_W'(3 * KEY_BITS));
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_center(CH_W'(0));
                1: write_center(CH_W'(2047));
                3: write_center(CH_W'(660));
                4: write_center(CH_W'(1387));
                6: write_center(CH_W'(1024));
                default: write_center(CH_W'($urandom_range(0, 2047)));
            endcase
            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            goal = beats_sent + PHASE_BEATS;
            while (beats_sent < goal) begin
                draw = $urandom_range(0, 19);
                if (draw < 14) begin
                    send_frame($urandom_range(0, 9) == 0, $urandom_range(0, 1));
                end else if (draw < 17) begin
                    send_beat(OP_READ, 8'($urandom), 1'($urandom), counter_pick());
                end else if (draw == 17) begin
                    send_beat(OP_PUSH, 8'($urandom), 1'b0, IDX_W'($urandom));
                    beats_sent--;
                end else if (draw == 18) begin
                    send_beat(OP_NONE, 8'($urandom), 1'($urandom), IDX_W'($urandom));
                    beats_sent--;
                end else if ($urandom_range(0, 3) == 0) begin
                    send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), IDX_W'($urandom));
                end else begin
                    send_beat(OP_READ, 8'($urandom), 1'($urandom), counter_pick());
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rfd_pkg.sv
rtl/core/rfd_collect.sv
rtl/core/rfd_counters.sv
rtl/core/remote_frame_decoder_with_key_edges.sv
dv/frame_decode_checker.sv
dv/testbench.sv
